FILE: design/quad_pitch_roll_pid_mixer_assert.svh
// Assertion macros for the pitch/roll PID mixer
`ifndef QUAD_PITCH_ROLL_PID_MIXER_ASSERT_SVH
`define QUAD_PITCH_ROLL_PID_MIXER_ASSERT_SVH

// expr must hold at every clock edge out of reset
`define QPRPM_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("qprpm check failed");

// cond at one edge implies conseq at the next edge
`define QPRPM_ASSERT_NEXT(lbl, clk, rst, cond, conseq) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("qprpm check failed");

`endif

FILE: design/qprpm_pkg.sv
// Package: widths, register indexes and controller/datapath interface types
package qprpm_pkg;

   localparam int AngleW  = 17;
   localparam int ErrW    = 18;
   localparam int SumW    = 19;
   localparam int DiffW   = 19;
   localparam int GainW   = 16;
   localparam int SpeedW  = 16;
   localparam int PeW     = GainW + ErrW;   // kp * e
   localparam int ProdW   = GainW + DiffW;  // ki * s, kd * diff
   localparam int QuoW    = ProdW;
   localparam int DqW     = QuoW + 1;
   localparam int AccW    = 53;
   localparam int TermW   = AccW - 16;
   localparam int MixW    = TermW + 2;
   localparam int CntW    = 6;
   localparam int CsrIdxW = 3;

   localparam logic signed [SumW-1:0] SumLimit = 19'sd256000;

   typedef enum logic [CsrIdxW-1:0] {
      REG_KP_PITCH = 3'd0,
      REG_KI_PITCH = 3'd1,
      REG_KD_PITCH = 3'd2,
      REG_KP_ROLL  = 3'd3,
      REG_KI_ROLL  = 3'd4,
      REG_KD_ROLL  = 3'd5,
      REG_DT       = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic signed [GainW-1:0] kp_pitch;
      logic signed [GainW-1:0] ki_pitch;
      logic signed [GainW-1:0] kd_pitch;
      logic signed [GainW-1:0] kp_roll;
      logic signed [GainW-1:0] ki_roll;
      logic signed [GainW-1:0] kd_roll;
      logic [15:0]             dt;
   } gains_type;

   typedef struct packed {
      logic load;
      logic axis;       // 0 pitch, 1 roll
      logic err;
      logic mul;
      logic div_start;
      logic scale_a;
      logic scale_b;
      logic acc;
      logic mix;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } stat_type;

endpackage

FILE: design/qprpm_dp.sv
// Datapath: error, clamped sum, multiplies, serial divider and motor mixing
module qprpm_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  qprpm_pkg::cmd_type          cmd,
   output qprpm_pkg::stat_type         stat,
   input  qprpm_pkg::gains_type        gains,
   input  logic signed [16:0]          pitch_target,
   input  logic signed [16:0]          pitch_measured,
   input  logic signed [16:0]          roll_target,
   input  logic signed [16:0]          roll_measured,
   input  logic [15:0]                 base_speed_0,
   input  logic [15:0]                 base_speed_1,
   input  logic [15:0]                 base_speed_2,
   input  logic [15:0]                 base_speed_3,
   output logic [15:0]                 speed_0,
   output logic [15:0]                 speed_1,
   output logic [15:0]                 speed_2,
   output logic [15:0]                 speed_3
);
   import qprpm_pkg::*;

   logic signed [AngleW-1:0] pt_ff, pm_ff, rt_ff, rm_ff;
   logic [SpeedW-1:0]        b0_ff, b1_ff, b2_ff, b3_ff;

   logic signed [ErrW-1:0]   pprev_ff, rprev_ff;
   logic signed [SumW-1:0]   psum_ff, rsum_ff;

   logic signed [ErrW-1:0]   e_ff, e_in;
   logic signed [SumW-1:0]   s_ff, s_in;
   logic signed [DiffW-1:0]  d_ff, d_in;
   logic signed [PeW-1:0]    pe_ff;
   logic signed [ProdW-1:0]  ks_ff, kdd_ff;
   logic                     neg_ff;
   logic [CntW-1:0]          cnt_ff, cnt_in;
   logic [15:0]              rem_ff, rem_in;
   logic [QuoW-1:0]          quo_ff, quo_in;
   logic [33:0]              lo_ff;
   logic signed [33:0]       hi_ff;
   logic signed [AccW-1:0]   idt_ff, idt_in;
   logic signed [AccW-1:0]   accp_ff, accr_ff, acc_in;
   logic [SpeedW-1:0]        o0_ff, o1_ff, o2_ff, o3_ff;

   logic signed [AngleW-1:0] tgt, meas;
   logic signed [ErrW-1:0]   prev_sel;
   logic signed [SumW-1:0]   sum_sel;
   logic signed [GainW-1:0]  kp, ki, kd;
   logic [15:0]              dt;
   logic signed [SumW:0]     s_wide;
   logic [16:0]              trial;
   logic                     ge;
   logic signed [DqW-1:0]    dq;
   logic signed [AccW-1:0]   adj_p, adj_r;
   logic signed [TermW-1:0]  tp, tr;
   logic                     tp_pos, tr_pos;
   logic [TermW-1:0]         mag_p, mag_r;
   logic [MixW-1:0]          m0, m1, m2, m3;

   function automatic logic [SpeedW-1:0] sat(input logic [MixW-1:0] v);
      sat = (|v[MixW-1:SpeedW]) ? {SpeedW{1'b1}} : v[SpeedW-1:0];
   endfunction

   assign tgt      = cmd.axis ? rt_ff : pt_ff;
   assign meas     = cmd.axis ? rm_ff : pm_ff;
   assign prev_sel = cmd.axis ? rprev_ff : pprev_ff;
   assign sum_sel  = cmd.axis ? rsum_ff : psum_ff;
   assign kp       = cmd.axis ? gains.kp_roll : gains.kp_pitch;
   assign ki       = cmd.axis ? gains.ki_roll : gains.ki_pitch;
   assign kd       = cmd.axis ? gains.kd_roll : gains.kd_pitch;
   // zero period counts as one
   assign dt       = (gains.dt == 16'd0) ? 16'd1 : gains.dt;

   always_comb begin
      e_in   = ErrW'(tgt) - ErrW'(meas);
      s_wide = (SumW+1)'(sum_sel) + (SumW+1)'(e_in);
      priority if (s_wide > (SumW+1)'(SumLimit)) begin
         s_in = SumLimit;
      end else if (s_wide < -(SumW+1)'(SumLimit)) begin
         s_in = -SumLimit;
      end else begin
         s_in = s_wide[SumW-1:0];
      end
      d_in = DiffW'(e_in) - DiffW'(prev_sel);
   end

   // one quotient bit per cycle on the magnitude
   always_comb begin
      trial  = {rem_ff, quo_ff[QuoW-1]};
      ge     = trial >= {1'b0, dt};
      rem_in = ge ? 16'(trial - {1'b0, dt}) : trial[15:0];
      quo_in = {quo_ff[QuoW-2:0], ge};
      cnt_in = cnt_ff - CntW'(1);
   end

   assign stat.div_busy = (cnt_ff != '0);
   assign dq = neg_ff ? -DqW'(quo_ff) : DqW'(quo_ff);

   assign idt_in = (AccW'(hi_ff) <<< 18) + AccW'({1'b0, lo_ff});
   assign acc_in = AccW'(pe_ff) + idt_ff + AccW'(dq);

   // truncate toward zero
   always_comb begin
      adj_p  = accp_ff + (accp_ff[AccW-1] ? AccW'(65535) : AccW'(0));
      adj_r  = accr_ff + (accr_ff[AccW-1] ? AccW'(65535) : AccW'(0));
      tp     = adj_p[AccW-1:16];
      tr     = adj_r[AccW-1:16];
      tp_pos = !tp[TermW-1] && (tp != '0);
      tr_pos = !tr[TermW-1] && (tr != '0);
      mag_p  = tp_pos ? tp : -tp;
      mag_r  = tr_pos ? tr : -tr;
      m0 = MixW'(b0_ff) + (tp_pos ? '0 : MixW'(mag_p)) + (tr_pos ? MixW'(mag_r) : '0);
      m1 = MixW'(b1_ff) + (tp_pos ? MixW'(mag_p) : '0) + (tr_pos ? MixW'(mag_r) : '0);
      m2 = MixW'(b2_ff) + (tp_pos ? MixW'(mag_p) : '0) + (tr_pos ? '0 : MixW'(mag_r));
      m3 = MixW'(b3_ff) + (tp_pos ? '0 : MixW'(mag_p)) + (tr_pos ? '0 : MixW'(mag_r));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pprev_ff <= '0;
         rprev_ff <= '0;
         psum_ff  <= '0;
         rsum_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         if (cmd.err) begin
            if (cmd.axis) begin
               rprev_ff <= e_in;
               rsum_ff  <= s_in;
            end else begin
               pprev_ff <= e_in;
               psum_ff  <= s_in;
            end
         end
         if (cmd.div_start) begin
            cnt_ff <= CntW'(QuoW);
         end else if (stat.div_busy) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pt_ff <= pitch_target;
         pm_ff <= pitch_measured;
         rt_ff <= roll_target;
         rm_ff <= roll_measured;
         b0_ff <= base_speed_0;
         b1_ff <= base_speed_1;
         b2_ff <= base_speed_2;
         b3_ff <= base_speed_3;
      end
      if (cmd.err) begin
         e_ff <= e_in;
         s_ff <= s_in;
         d_ff <= d_in;
      end
      if (cmd.mul) begin
         pe_ff  <= PeW'(kp) * PeW'(e_ff);
         ks_ff  <= ProdW'(ki) * ProdW'(s_ff);
         kdd_ff <= ProdW'(kd) * ProdW'(d_ff);
      end
      if (cmd.div_start) begin
         neg_ff <= kdd_ff[ProdW-1];
         quo_ff <= kdd_ff[ProdW-1] ? QuoW'(-kdd_ff) : QuoW'(kdd_ff);
         rem_ff <= '0;
      end else if (stat.div_busy) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.scale_a) begin
         lo_ff <= 34'(ks_ff[17:0]) * 34'(dt);
         hi_ff <= 34'(signed'(ks_ff[ProdW-1:18])) * 34'(signed'({1'b0, dt}));
      end
      if (cmd.scale_b) begin
         idt_ff <= idt_in;
      end
      if (cmd.acc) begin
         if (cmd.axis) begin
            accr_ff <= acc_in;
         end else begin
            accp_ff <= acc_in;
         end
      end
      if (cmd.mix) begin
         o0_ff <= sat(m0);
         o1_ff <= sat(m1);
         o2_ff <= sat(m2);
         o3_ff <= sat(m3);
      end
   end

   assign speed_0 = o0_ff;
   assign speed_1 = o1_ff;
   assign speed_2 = o2_ff;
   assign speed_3 = o3_ff;

endmodule

FILE: design/qprpm_ctrl.sv
// Controller: sequences both axes through the datapath and owns the handshakes
module qprpm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output qprpm_pkg::cmd_type  cmd,
   input  qprpm_pkg::stat_type stat
);
   import qprpm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ERR, S_MUL, S_DIVLD, S_DIV, S_SCA, S_SCB, S_ACC, S_MIX
   } state_type;

   state_type state_ff;
   logic      axis_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.axis      = axis_ff;
      cmd.load      = (state_ff == S_IDLE) && req_valid;
      cmd.err       = (state_ff == S_ERR);
      cmd.mul       = (state_ff == S_MUL);
      cmd.div_start = (state_ff == S_DIVLD);
      cmd.scale_a   = (state_ff == S_SCA);
      cmd.scale_b   = (state_ff == S_SCB);
      cmd.acc       = (state_ff == S_ACC);
      cmd.mix       = (state_ff == S_MIX) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.mix) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  axis_ff  <= 1'b0;
                  state_ff <= S_ERR;
               end
            end
            S_ERR:   state_ff <= S_MUL;
            S_MUL:   state_ff <= S_DIVLD;
            S_DIVLD: state_ff <= S_DIV;
            S_DIV: begin
               if (!stat.div_busy) begin
                  state_ff <= S_SCA;
               end
            end
            S_SCA:   state_ff <= S_SCB;
            S_SCB:   state_ff <= S_ACC;
            S_ACC: begin
               if (axis_ff) begin
                  state_ff <= S_MIX;
               end else begin
                  axis_ff  <= 1'b1;
                  state_ff <= S_ERR;
               end
            end
            S_MIX: begin
               // hold until the output register is free
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: design/quad_pitch_roll_pid_mixer.sv
// An accepted req beat runs the pitch axis, then the roll axis, then the mix before rsp_valid.
// A new req is taken only in idle, after the mix; the 35-step restoring divider of the
// derivative term runs once per axis and takes most of the time per item.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous) clears the error sums and previous errors and loads the
// default gains; no clearing pass.
module quad_pitch_roll_pid_mixer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [16:0] req_pitch_target,
   input  logic signed [16:0] req_pitch_measured,
   input  logic signed [16:0] req_roll_target,
   input  logic signed [16:0] req_roll_measured,
   input  logic [15:0]        req_base_speed_0,
   input  logic [15:0]        req_base_speed_1,
   input  logic [15:0]        req_base_speed_2,
   input  logic [15:0]        req_base_speed_3,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_speed_0,
   output logic [15:0]        rsp_speed_1,
   output logic [15:0]        rsp_speed_2,
   output logic [15:0]        rsp_speed_3,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import qprpm_pkg::*;

   `include "quad_pitch_roll_pid_mixer_assert.svh"

   gains_type gains_ff;
   cmd_type   cmd;
   stat_type  stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.kp_pitch <= 16'sd717;
         gains_ff.ki_pitch <= '0;
         gains_ff.kd_pitch <= '0;
         gains_ff.kp_roll  <= 16'sd712;
         gains_ff.ki_roll  <= '0;
         gains_ff.kd_roll  <= '0;
         gains_ff.dt       <= 16'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_KP_PITCH: gains_ff.kp_pitch <= signed'(csr_wdata);
            REG_KI_PITCH: gains_ff.ki_pitch <= signed'(csr_wdata);
            REG_KD_PITCH: gains_ff.kd_pitch <= signed'(csr_wdata);
            REG_KP_ROLL:  gains_ff.kp_roll  <= signed'(csr_wdata);
            REG_KI_ROLL:  gains_ff.ki_roll  <= signed'(csr_wdata);
            REG_KD_ROLL:  gains_ff.kd_roll  <= signed'(csr_wdata);
            REG_DT:       gains_ff.dt       <= csr_wdata;
            default: ;    // drop writes beyond the list
         endcase
      end
   end

   qprpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   qprpm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .gains          (gains_ff),
      .pitch_target   (req_pitch_target),
      .pitch_measured (req_pitch_measured),
      .roll_target    (req_roll_target),
      .roll_measured  (req_roll_measured),
      .base_speed_0   (req_base_speed_0),
      .base_speed_1   (req_base_speed_1),
      .base_speed_2   (req_base_speed_2),
      .base_speed_3   (req_base_speed_3),
      .speed_0        (rsp_speed_0),
      .speed_1        (rsp_speed_1),
      .speed_2        (rsp_speed_2),
      .speed_3        (rsp_speed_3)
   );

   `QPRPM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `QPRPM_ASSERT_ALWAYS(a_div_only_busy, clock, reset, !(stat.div_busy && req_ready))
   `QPRPM_ASSERT_ALWAYS(a_mix_only_busy, clock, reset, !(cmd.mix && req_ready))
   `QPRPM_ASSERT_NEXT(a_mix_sets_valid, clock, reset, cmd.mix, rsp_valid)

endmodule
